/* rtl/assert_macros.svh */
// Concurrent assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/lcdcsr_pkg.sv */
package lcdcsr_pkg;

  localparam int NumRegs = 20;
  localparam int RegIdxW = 5;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_TICK  = 2'd2
  } req_e;

  // Register numbers
  localparam logic [RegIdxW-1:0] R_REVID       = 5'd0;
  localparam logic [RegIdxW-1:0] R_MODE_CFG    = 5'd1;
  localparam logic [RegIdxW-1:0] R_LCD_STAT    = 5'd2;
  localparam logic [RegIdxW-1:0] R_LIDD_CTRL   = 5'd3;
  localparam logic [RegIdxW-1:0] R_CS0_CONF    = 5'd4;
  localparam logic [RegIdxW-1:0] R_CS0_ADDR    = 5'd5;
  localparam logic [RegIdxW-1:0] R_CS0_DATA    = 5'd6;
  localparam logic [RegIdxW-1:0] R_SCAN_CFG    = 5'd10;
  localparam logic [RegIdxW-1:0] R_DMA_CFG     = 5'd15;

  localparam logic [31:0] RevidReset   = 32'h4c10_0100;
  localparam logic [31:0] Cs0ConfReset = 32'h0022_0044;

  // Status bits
  localparam logic [31:0] StDone = 32'h0000_0001;
  localparam logic [31:0] StSync = 32'h0000_0004;
  localparam logic [31:0] StFuf  = 32'h0000_0020;
  localparam logic [31:0] StPl   = 32'h0000_0040;
  localparam logic [31:0] StEof0 = 32'h0000_0100;
  localparam logic [31:0] StEof1 = 32'h0000_0200;

  // Palette modes
  localparam logic [1:0] PalPaletteOnly = 2'd1;
  localparam logic [1:0] PalRawOnly     = 2'd3;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [RegIdxW-1:0] reg_index;
    logic [31:0]        write_data;
    logic               frame_fetch_failed;
  } in_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_pulse;
    logic        lidd_addr_strobe;
    logic        lidd_data_strobe;
    logic [31:0] lidd_value;
  } out_t;

  function automatic logic [31:0] reg_reset_value(logic [RegIdxW-1:0] idx);
    logic [31:0] val;
    case (idx)
      R_REVID:    val = RevidReset;
      R_CS0_CONF: val = Cs0ConfReset;
      default:    val = '0;
    endcase
    return val;
  endfunction

endpackage

/* rtl/lcdcsr_regfile.sv */
module lcdcsr_regfile (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  lcdcsr_pkg::in_t     item_i,
  output lcdcsr_pkg::out_t    res_o
);
  import lcdcsr_pkg::*;

  `include "assert_macros.svh"

  logic [31:0] regs_q [NumRegs];
  logic [31:0] regs_d [NumRegs];
  logic        lidd;
  logic        scan_on;
  logic [1:0]  plm;
  logic        in_range;
  logic [31:0] stat;
  logic [31:0] clr;
  out_t        res;

  assign lidd      = !regs_q[R_MODE_CFG][0];
  assign scan_on   = regs_q[R_SCAN_CFG][0];
  assign plm       = regs_q[R_SCAN_CFG][21:20];
  assign in_range  = item_i.reg_index < RegIdxW'(NumRegs);
  assign stat      = regs_q[R_LCD_STAT];

  always_comb begin
    regs_d = regs_q;
    res    = '0;
    clr    = '0;
    unique case (item_i.req_type)
      REQ_READ: begin
        if (in_range) begin
          res.read_data = regs_q[item_i.reg_index];
        end
      end
      REQ_WRITE: begin
        if (in_range && item_i.reg_index != R_REVID) begin
          unique case (item_i.reg_index)
            R_LCD_STAT: begin
              // write-one-to-clear
              regs_d[R_LCD_STAT] = stat & ~item_i.write_data;
            end
            R_LIDD_CTRL: begin
              if (lidd) begin
                regs_d[R_LIDD_CTRL] = item_i.write_data;
              end
            end
            default: begin
              regs_d[item_i.reg_index] = item_i.write_data;
              if (item_i.reg_index == R_CS0_ADDR && lidd) begin
                res.lidd_addr_strobe = 1'b1;
                res.lidd_value       = item_i.write_data;
              end else if (item_i.reg_index == R_CS0_DATA && lidd) begin
                res.lidd_data_strobe = 1'b1;
                res.lidd_value       = item_i.write_data;
              end else if (item_i.reg_index == R_SCAN_CFG && !lidd) begin
                // palette mode comes from the value just written
                clr = StDone | StEof0 | StEof1;
                if (!item_i.write_data[0]) begin
                  clr = clr | StFuf | StSync;
                  if (item_i.write_data[21:20] == PalPaletteOnly) begin
                    clr = clr | StPl;
                  end
                end
                regs_d[R_LCD_STAT] = stat & ~clr;
              end
            end
          endcase
        end
      end
      REQ_TICK: begin
        if (!lidd && scan_on) begin
          if (plm == PalPaletteOnly) begin
            regs_d[R_LCD_STAT] = stat | StPl;
            res.irq_pulse      = regs_q[R_SCAN_CFG][4];
          end else if (plm != PalRawOnly && item_i.frame_fetch_failed) begin
            regs_d[R_LCD_STAT] = stat | StSync;
            res.irq_pulse      = regs_q[R_SCAN_CFG][5];
          end else begin
            regs_d[R_LCD_STAT] = stat | StDone | StEof0;
            res.irq_pulse      = regs_q[R_DMA_CFG][2];
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        regs_q[i] <= reg_reset_value(RegIdxW'(i));
      end
    end else if (en_i) begin
      regs_q <= regs_d;
    end
  end

  assign res_o = res;

  `ASSERT_ALWAYS(a_revid_const, regs_q[R_REVID] == RevidReset, "REVID changed")
  `ASSERT_ALWAYS(a_strobe_lidd,
      !(res.lidd_addr_strobe || res.lidd_data_strobe) ||
      (lidd && !(res.lidd_addr_strobe && res.lidd_data_strobe)),
      "LIDD strobe outside LIDD mode or both strobes raised")
  `ASSERT_ALWAYS(a_irq_tick_only,
      !res.irq_pulse || (item_i.req_type == REQ_TICK && !lidd && scan_on),
      "interrupt raised by a non-tick item")

endmodule

/* rtl/lcd_controller_status_registers_top.sv */
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i / in_stall_o | in_i  (lcdcsr_pkg::in_t)
// out     | output    | out_valid_o / out_stall_i | out_o (lcdcsr_pkg::out_t)
//
// One beat per cycle unless stalled; a request's result beat comes in the next cycle.
// Register file and status update at the edge the request beat is taken.
// Throughput is set by the single output register, refilled as it drains.
// A stalled output holds its beat and stalls the input in the same cycle.
// Reset (rst_ni low, asynchronous) loads the register reset values, empties the output.
module lcd_controller_status_registers_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lcdcsr_pkg::in_t   in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lcdcsr_pkg::out_t  out_o
);
  import lcdcsr_pkg::*;

  `include "assert_macros.svh"

  logic out_valid_q;
  logic out_valid_d;
  out_t out_q;
  out_t res;
  logic accept;

  // take a new beat whenever the output register empties or is drained
  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_d = accept || (out_valid_q && out_stall_i);

  lcdcsr_regfile u_regfile (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (accept),
    .item_i (in_i),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `ASSERT_NEXT(a_accept_fills, accept, out_valid_q, "accepted beat lost")
  `ASSERT_NEXT(a_out_hold, out_valid_q && out_stall_i, out_valid_q && $stable(out_q), "stalled beat changed")
  `ASSERT_ALWAYS(a_stall_needs_beat, !in_stall_o || out_valid_q, "input stalled with empty output")

endmodule
